// ----- sv/bpl_pkg.sv -----
// bpl_pkg: shared types and constants for the bounded positional list
// operation codes, status codes, controller states and the cell control bundle
// no dependencies
package bpl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 5;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 3;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FIRST = 3'd0,
    K_INS_POS   = 3'd1,
    K_INS_LAST  = 3'd2,
    K_DEL_FIRST = 3'd3,
    K_DEL_POS   = 3'd4,
    K_DEL_LAST  = 3'd5,
    K_SEARCH    = 3'd6,
    K_READOUT   = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_LOAD,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- sv/bounded_positional_list_top.sv -----
// bounded_positional_list_top: ordered list of up to CAPACITY signed 32-bit values
// a row of bpl_cell slots driven by the bpl_ctrl sequencer
// depends on bpl_pkg, bpl_cell, bpl_ctrl
//
// input channel in_valid/in_stall carries kind, value and position; each item is
// one list operation. output channel out_valid/out_stall carries status,
// value_res, position_res and last; last marks the final result of an item.
// one item is worked on at a time; in_stall is high from the cycle after an item
// is taken until its final result has been loaded into the output register.
// insert and every error are settled in the exec state, with no scan.
// delete at position p walks the scan to p; search stops at the first match
// or, on a miss, after all n elements; read-out of n elements gives one element
// per cycle while the output is not stalled. the scan copy in the cell chain
// moves one slot toward the head on each shift.
// a result held under out_stall keeps its payload; the next item is taken but
// starts only once the output is free; its scan then pauses only to load a result.
// rst is synchronous and empties the list; element contents are not cleared.
module bounded_positional_list_top #(
  parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpl_pkg::KIND_W-1:0]          kind,
  input  logic signed [bpl_pkg::VAL_W-1:0]    value,
  input  logic [bpl_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpl_pkg::STATUS_W-1:0]        status,
  output logic signed [bpl_pkg::VAL_W-1:0]    value_res,
  output logic [bpl_pkg::POS_W-1:0]           position_res,
  output logic                                last
);
  import bpl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  cell_ctl_t               cell_ctl;
  logic [IDX_W-1:0]        cell_idx;
  logic signed [VAL_W-1:0] elem [CAPACITY];
  logic signed [VAL_W-1:0] scan [CAPACITY];

  bpl_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_res   (value_res),
    .position_res(position_res),
    .last        (last),
    .cell_ctl    (cell_ctl),
    .cell_idx    (cell_idx),
    .head_scan   (scan[0])
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [VAL_W-1:0] prev_elem;
    logic signed [VAL_W-1:0] next_elem;
    logic signed [VAL_W-1:0] next_scan;

    if (j == 0) begin : g_head
      assign prev_elem = '0;
    end else begin : g_body
      assign prev_elem = elem[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign next_elem = '0;
      assign next_scan = '0;
    end else begin : g_link
      assign next_elem = elem[j+1];
      assign next_scan = scan[j+1];
    end

    bpl_cell #(
      .IDX_W(IDX_W),
      .J    (j)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .idx      (cell_idx),
      .prev_elem(prev_elem),
      .next_elem(next_elem),
      .next_scan(next_scan),
      .elem     (elem[j]),
      .scan     (scan[j])
    );
  end

endmodule

// ----- sv/bpl_cell.sv -----
// bpl_cell: one slot of the list chain, holding an element and a scan copy
// shifts elements on insert/delete and scan copies toward the head
// depends on bpl_pkg
module bpl_cell #(
  parameter int IDX_W = 4,
  parameter int J     = 0
) (
  input  logic                             clk,
  input  bpl_pkg::cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]                 idx,
  input  logic signed [bpl_pkg::VAL_W-1:0] prev_elem,
  input  logic signed [bpl_pkg::VAL_W-1:0] next_elem,
  input  logic signed [bpl_pkg::VAL_W-1:0] next_scan,
  output logic signed [bpl_pkg::VAL_W-1:0] elem,
  output logic signed [bpl_pkg::VAL_W-1:0] scan
);
  import bpl_pkg::*;

  localparam logic [IDX_W-1:0] J_IDX = IDX_W'(J);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CELL_INS: begin
        if (idx < J_IDX) begin
          elem <= prev_elem;
        end else if (idx == J_IDX) begin
          elem <= ctl.value;
        end
      end
      CELL_DEL: begin
        if (idx <= J_IDX) begin
          elem <= next_elem;
        end
      end
      CELL_LOAD: begin
        scan <= elem;
      end
      CELL_SHIFT: begin
        scan <= next_scan;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/bpl_ctrl.sv -----
// bpl_ctrl: sequencer for the list chain, element count and result register
// decodes each item, drives the cell chain and walks the scan head
// depends on bpl_pkg
module bpl_ctrl #(
  parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bpl_pkg::KIND_W-1:0]          kind,
  input  logic signed [bpl_pkg::VAL_W-1:0]    value,
  input  logic [bpl_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bpl_pkg::STATUS_W-1:0]        status,
  output logic signed [bpl_pkg::VAL_W-1:0]    value_res,
  output logic [bpl_pkg::POS_W-1:0]           position_res,
  output logic                                last,
  output bpl_pkg::cell_ctl_t                  cell_ctl,
  output logic [$clog2(CAPACITY)-1:0]         cell_idx,
  input  logic signed [bpl_pkg::VAL_W-1:0]    head_scan
);
  import bpl_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CW    = W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  kind_t                    op_kind;
  logic signed [VAL_W-1:0]  op_val;
  logic [POS_W-1:0]         op_pos;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_next;
  logic [CNT_W-1:0]         pos_cnt;
  logic [CNT_W-1:0]         pos_cnt_next;

  logic                     accept;
  logic                     slot_free;
  logic                     to_scan;
  logic                     done;
  logic                     res_load;
  status_t                  res_status;
  logic signed [VAL_W-1:0]  res_value;
  logic [POS_W-1:0]         res_pos;
  logic                     res_last;

  logic                     is_full;
  logic                     is_empty;
  logic [CW-1:0]            pos_w;
  logic [CW-1:0]            cnt_w;
  logic                     ins_bad;
  logic                     del_bad;
  logic [POS_W-1:0]         pos_m1;
  logic [IDX_W-1:0]         ins_idx;
  logic [IDX_W-1:0]         del_idx;
  logic [W-1:0]             ins_pos1;
  logic [W-1:0]             scan_pos1;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  assign is_full   = (count == CAP_CNT);
  assign is_empty  = (count == '0);
  assign pos_w     = CW'(op_pos);
  assign cnt_w     = CW'(count);
  assign ins_bad   = (pos_w == '0) || (pos_w > cnt_w + CW'(1));
  assign del_bad   = (pos_w == '0) || (pos_w > cnt_w);
  assign pos_m1    = op_pos - POS_W'(1);
  assign scan_pos1 = W'(pos_cnt) + W'(1);
  assign ins_pos1  = W'(ins_idx) + W'(1);

  always_comb begin
    case (op_kind)
      K_INS_FIRST: ins_idx = '0;
      K_INS_LAST:  ins_idx = IDX_W'(count);
      default:     ins_idx = IDX_W'(pos_m1);
    endcase
    case (op_kind)
      K_DEL_FIRST: del_idx = '0;
      K_DEL_LAST:  del_idx = IDX_W'(count - CNT_W'(1));
      default:     del_idx = IDX_W'(pos_m1);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_next = S_IDLE;
        end else if (to_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_ctl.cmd   = CELL_HOLD;
    cell_ctl.value = op_val;
    cell_idx       = idx;
    res_load       = 1'b0;
    res_status     = ST_OK;
    res_value      = '0;
    res_pos        = '0;
    res_last       = 1'b1;
    count_next     = count;
    idx_next       = idx;
    pos_cnt_next   = pos_cnt;
    to_scan        = 1'b0;
    done           = 1'b0;
    case (state)
      S_EXEC: begin
        if (slot_free) begin
          case (op_kind)
            K_INS_FIRST, K_INS_POS, K_INS_LAST: begin
              done     = 1'b1;
              res_load = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else if (op_kind == K_INS_POS && ins_bad) begin
                res_status = ST_BADPOS;
              end else begin
                cell_ctl.cmd = CELL_INS;
                cell_idx     = ins_idx;
                count_next   = count + CNT_W'(1);
                res_value    = op_val;
                res_pos      = ins_pos1[POS_W-1:0];
              end
            end
            K_DEL_FIRST, K_DEL_POS, K_DEL_LAST: begin
              if (is_empty) begin
                done       = 1'b1;
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else if (op_kind == K_DEL_POS && del_bad) begin
                done       = 1'b1;
                res_load   = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                cell_ctl.cmd = CELL_LOAD;
                idx_next     = del_idx;
                pos_cnt_next = '0;
                to_scan      = 1'b1;
              end
            end
            default: begin
              if (is_empty) begin
                done       = 1'b1;
                res_load   = 1'b1;
                res_status = (op_kind == K_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
              end else begin
                cell_ctl.cmd = CELL_LOAD;
                pos_cnt_next = '0;
                to_scan      = 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        case (op_kind)
          K_DEL_FIRST, K_DEL_POS, K_DEL_LAST: begin
            if (pos_cnt == CNT_W'(idx)) begin
              if (slot_free) begin
                cell_ctl.cmd = CELL_DEL;
                count_next   = count - CNT_W'(1);
                done         = 1'b1;
                res_load     = 1'b1;
                res_value    = head_scan;
                res_pos      = scan_pos1[POS_W-1:0];
              end
            end else begin
              cell_ctl.cmd = CELL_SHIFT;
              pos_cnt_next = pos_cnt + CNT_W'(1);
            end
          end
          K_SEARCH: begin
            if (pos_cnt == count) begin
              if (slot_free) begin
                done       = 1'b1;
                res_load   = 1'b1;
                res_status = ST_NOTFOUND;
              end
            end else if (head_scan == op_val) begin
              if (slot_free) begin
                done      = 1'b1;
                res_load  = 1'b1;
                res_value = op_val;
                res_pos   = scan_pos1[POS_W-1:0];
              end
            end else begin
              cell_ctl.cmd = CELL_SHIFT;
              pos_cnt_next = pos_cnt + CNT_W'(1);
            end
          end
          default: begin
            if (slot_free) begin
              cell_ctl.cmd = CELL_SHIFT;
              pos_cnt_next = pos_cnt + CNT_W'(1);
              res_load     = 1'b1;
              res_value    = head_scan;
              res_pos      = scan_pos1[POS_W-1:0];
              res_last     = (W'(count) == scan_pos1);
              done         = res_last;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= kind_t'(kind);
      op_val  <= value;
      op_pos  <= position;
    end
    idx     <= idx_next;
    pos_cnt <= pos_cnt_next;
    if (res_load) begin
      status       <= res_status;
      value_res    <= res_value;
      position_res <= res_pos;
      last         <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("element count above capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != '0)
    else $error("scan running on an empty list");

  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> pos_cnt <= count)
    else $error("scan position past the list end");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && res_load && (op_kind == K_DEL_FIRST || op_kind == K_DEL_POS ||
     op_kind == K_DEL_LAST)) |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_readout_cont: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && op_kind == K_READOUT && res_load && !res_last) |=> state == S_SCAN)
    else $error("read-out stopped before the last element");
`endif

endmodule
